/* sv/ttnd_pkg.sv */
// types and constants shared by the token table name decoder
`timescale 1ns / 1ps

package ttnd_pkg;

	// request kinds on the input channel
	localparam logic [1:0] REQ_IDX  = 2'd0;
	localparam logic [1:0] REQ_TBL  = 2'd1;
	localparam logic [1:0] REQ_NAME = 2'd2;

	// status codes carried by the done marker
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_LEN     = 3'd1;
	localparam logic [2:0] ST_BAD_IDX = 3'd2;
	localparam logic [2:0] ST_OVERRUN = 3'd3;
	localparam logic [2:0] ST_OVF     = 3'd4;
	localparam logic [2:0] ST_LONG    = 3'd5;

	// fixed geometry
	localparam int INDEX_ENTRIES = 256;
	localparam int IDX_AW        = 8;
	localparam int TOK_CNT_W     = 6;
	localparam int LEN_W         = 15;
	localparam int SPACE_W       = 9;
	localparam logic [SPACE_W-1:0] OUT_LIMIT_RST = 9'd256;

	// position inside the encoded name
	typedef enum logic [1:0] {
		PH_HDR1,
		PH_HDR2,
		PH_CODES
	} phase_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_IDX_RD,
		S_IDX_CHK,
		S_TBL_RD,
		S_TBL_CHK,
		S_DONE
	} state_t;

endpackage

/* sv/ttnd_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ttnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/token_table_name_decoder.sv */
// top level of the token table name decoder
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// request  | req_valid/req_stall  | req_type, table_addr, table_data, code_byte
// response | rsp_valid/rsp_stall  | out_char, char_valid, name_done, status
// config   | cfg_wr_en            | cfg_wr_data (out_limit)
//
// write and header transactions are taken in the idle state; a closing done marker is
// loaded into the response register in the done state and then leaves it.
// a code byte reads its index entry, checks it, then walks the token: each table
// byte is one read of the single table ram read port followed by a check.
// one request is worked on at a time; no new request while a response is pending.
// a stalled response holds the token walk at the character waiting to go out.
// reset clears control state only; both rams are undefined until written, no clearing pass.
`timescale 1ns / 1ps

module token_table_name_decoder
	import ttnd_pkg::*;
#(
	parameter int TABLE_BYTES  = 2048,
	parameter int MAX_NAME_LEN = 256,
	parameter int MAX_TOKEN    = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [10:0] table_addr,
	input  logic [15:0] table_data,
	input  logic [7:0]  code_byte,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  out_char,
	output logic        char_valid,
	output logic        name_done,
	output logic [2:0]  status
);

	localparam int TA_W = $clog2(TABLE_BYTES);
	localparam int WA_W = TA_W + 1;
	localparam logic [16:0]     TBL_END17 = 17'(TABLE_BYTES);
	localparam logic [WA_W-1:0] TBL_END   = WA_W'(TABLE_BYTES);
	localparam logic [TOK_CNT_W-1:0] TOK_MAX = TOK_CNT_W'(MAX_TOKEN);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME_LEN);

	state_t state_q, state_d;
	phase_t phase_q;

	logic [SPACE_W-1:0]   out_limit_q;
	logic [LEN_W-1:0]     rem_q;
	logic                 first_q;
	logic [SPACE_W-1:0]   space_q;
	logic [2:0]           err_q;
	logic [7:0]           code_q;
	logic [WA_W-1:0]      addr_q;
	logic [TOK_CNT_W-1:0] count_q;

	logic       rsp_valid_q;
	logic [7:0] out_char_q;
	logic       char_valid_q;
	logic       name_done_q;
	logic [2:0] status_q;

	logic        accept, name_acc, out_free;
	logic        hdr_two, len_zero, len_long, walk_go;
	logic [LEN_W-1:0] hdr_len;
	logic        idx_bad, tbl_over, ch_nul, tok_long, space_ok;
	logic        ld_char, ld_done;
	logic        idx_we, tbl_we;
	logic [15:0] idx_rdata;
	logic [7:0]  tbl_rdata;

	// handshake and decode of a name byte
	assign accept   = req_valid && !req_stall;
	assign name_acc = accept && (req_type == REQ_NAME);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign hdr_two  = (phase_q == PH_HDR1) && code_byte[7];
	assign hdr_len  = (phase_q == PH_HDR2) ? {code_byte, rem_q[6:0]} : LEN_W'(code_byte);
	assign len_zero = (hdr_len == '0);
	assign len_long = (hdr_len > LEN_MAX);
	assign space_ok = (space_q > 9'd1);
	assign walk_go  = (err_q == ST_OK) && space_ok;

	// token walk checks
	assign idx_bad  = (17'(idx_rdata) >= TBL_END17);
	assign tbl_over = (addr_q >= TBL_END);
	assign ch_nul   = (tbl_rdata == 8'd0);
	assign tok_long = (count_q == TOK_MAX);

	// memory write decode
	assign idx_we = accept && (req_type == REQ_IDX) && (table_addr[10:IDX_AW] == '0);
	assign tbl_we = accept && (req_type == REQ_TBL) && (17'(table_addr) < TBL_END17);

	ttnd_ram #(
		.WIDTH(16),
		.DEPTH(INDEX_ENTRIES)
	) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (table_addr[IDX_AW-1:0]),
		.wdata (table_data),
		.raddr (code_q),
		.rdata (idx_rdata)
	);

	ttnd_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_BYTES)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TA_W'(table_addr)),
		.wdata (table_data[7:0]),
		.raddr (addr_q[TA_W-1:0]),
		.rdata (tbl_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (name_acc) begin
					if (phase_q == PH_CODES) begin
						if (walk_go) begin
							state_d = S_IDX_RD;
						end else if (rem_q == LEN_W'(1)) begin
							state_d = S_DONE;
						end
					end else if (!hdr_two && len_zero) begin
						state_d = S_DONE;
					end
				end
			end
			S_IDX_RD: begin
				state_d = S_IDX_CHK;
			end
			S_IDX_CHK: begin
				if (idx_bad) begin
					state_d = (rem_q == '0) ? S_DONE : S_IDLE;
				end else begin
					state_d = S_TBL_RD;
				end
			end
			S_TBL_RD: begin
				if (tbl_over) begin
					state_d = (rem_q == '0) ? S_DONE : S_IDLE;
				end else begin
					state_d = S_TBL_CHK;
				end
			end
			S_TBL_CHK: begin
				priority if (ch_nul || tok_long || (first_q && !space_ok)) begin
					state_d = (rem_q == '0) ? S_DONE : S_IDLE;
				end else if (!first_q || out_free) begin
					state_d = S_TBL_RD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = !((state_q == S_IDLE) && !rsp_valid_q);
		ld_char   = (state_q == S_TBL_CHK) && !ch_nul && !tok_long && first_q
			&& space_ok && out_free;
		ld_done   = (state_q == S_DONE) && out_free;
	end

	// sequencer and name control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_HDR1;
			out_limit_q <= OUT_LIMIT_RST;
			rem_q       <= '0;
			first_q     <= 1'b0;
			space_q     <= OUT_LIMIT_RST;
			err_q       <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				out_limit_q <= cfg_wr_data;
			end
			// header and code byte bookkeeping
			if (name_acc) begin
				if (phase_q == PH_CODES) begin
					rem_q <= rem_q - LEN_W'(1);
					if (rem_q == LEN_W'(1)) begin
						phase_q <= PH_HDR1;
					end
				end else begin
					if (phase_q == PH_HDR1) begin
						first_q <= 1'b0;
						space_q <= out_limit_q;
					end
					if (hdr_two) begin
						rem_q   <= LEN_W'(code_byte[6:0]);
						phase_q <= PH_HDR2;
						err_q   <= ST_OK;
					end else begin
						rem_q   <= hdr_len;
						err_q   <= len_long ? ST_LEN : ST_OK;
						phase_q <= len_zero ? PH_HDR1 : PH_CODES;
					end
				end
			end
			// errors and progress of the token walk
			if ((state_q == S_IDX_CHK) && idx_bad) begin
				err_q <= ST_BAD_IDX;
			end
			if ((state_q == S_TBL_RD) && tbl_over) begin
				err_q <= ST_OVERRUN;
			end
			if ((state_q == S_TBL_CHK) && !ch_nul) begin
				priority if (tok_long) begin
					err_q <= ST_LONG;
				end else if (!first_q) begin
					first_q <= 1'b1;
				end else if (!space_ok) begin
					err_q <= ST_OVF;
				end else if (out_free) begin
					space_q <= space_q - 9'd1;
				end
			end
			// response register occupancy
			if (ld_char || ld_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// walk pointers and response payload
	always_ff @(posedge clk) begin
		if (name_acc) begin
			code_q <= code_byte;
		end
		if ((state_q == S_IDX_CHK) && !idx_bad) begin
			addr_q  <= WA_W'(idx_rdata);
			count_q <= '0;
		end
		if ((state_q == S_TBL_CHK) && !ch_nul && !tok_long
			&& (!first_q || (space_ok && out_free))) begin
			addr_q  <= addr_q + WA_W'(1);
			count_q <= count_q + TOK_CNT_W'(1);
		end
		if (ld_char) begin
			out_char_q   <= tbl_rdata;
			char_valid_q <= 1'b1;
			name_done_q  <= 1'b0;
			status_q     <= ST_OK;
		end
		if (ld_done) begin
			out_char_q   <= 8'd0;
			char_valid_q <= 1'b0;
			name_done_q  <= 1'b1;
			status_q     <= err_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign out_char   = out_char_q;
	assign char_valid = char_valid_q;
	assign name_done  = name_done_q;
	assign status     = status_q;

endmodule

/* sv/ttnd_checker.sv */
// port level checker for the token table name decoder and its bind
`timescale 1ns / 1ps

module ttnd_checker
	import ttnd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [8:0]  cfg_wr_data,
	input logic        req_valid,
	input logic        req_stall,
	input logic [1:0]  req_type,
	input logic [10:0] table_addr,
	input logic [15:0] table_data,
	input logic [7:0]  code_byte,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [7:0]  out_char,
	input logic        char_valid,
	input logic        name_done,
	input logic [2:0]  status
);

	// a stalled response transaction keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(out_char)
			&& $stable(char_valid) && $stable(name_done) && $stable(status))
		else $error("response changed while stalled");

	// every response is either a character or a done marker, never both
	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (char_valid != name_done))
		else $error("response is neither or both of character and done");

	// character responses carry a clean status
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && char_valid |-> status == ST_OK)
		else $error("character response with non-zero status");

	// done markers carry a zero character and a known status code
	a_done_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && name_done |-> out_char == 8'd0
			&& status != 3'd6 && status != 3'd7)
		else $error("malformed done marker");

	// no request is taken while a response waits
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken with a response pending");

endmodule

bind token_table_name_decoder ttnd_checker u_ttnd_checker (.*);
